// ===== rtl/core/ofpv_pkg.sv =====
package ofpv_pkg;

    localparam int TIME_W   = 48;
    localparam int EXPO_W   = 24;
    localparam int CYCLE_W  = 32;
    localparam int DELTA_W  = 16;
    localparam int QUAL_W   = 8;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [3:0] {
        RSN_NONE          = 4'd0,
        RSN_TIMEOUT       = 4'd1,
        RSN_LOW_QUALITY   = 4'd2,
        RSN_BAD_STAMP     = 4'd3,
        RSN_TIME_SKEW     = 4'd4,
        RSN_BAD_EXPOSURE  = 4'd5,
        RSN_EXPOSURE_SKEW = 4'd6,
        RSN_DELTA_OUTLIER = 4'd7,
        RSN_SOURCE_BAD    = 4'd8,
        RSN_CYCLE_MISMATCH = 4'd9
    } reason_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIMEOUT_LIMIT       = 3'd0,
        REG_QUALITY_FLOOR       = 3'd1,
        REG_DELTA_X_LIMIT       = 3'd2,
        REG_DELTA_Y_LIMIT       = 3'd3,
        REG_SKEW_LIMIT          = 3'd4,
        REG_EXPOSURE_SKEW_LIMIT = 3'd5
    } reg_index_t;

    localparam logic [EXPO_W-1:0]  TIMEOUT_LIMIT_RST       = 24'd100000;
    localparam logic [QUAL_W-1:0]  QUALITY_FLOOR_RST       = 8'd0;
    localparam logic [DELTA_W-1:0] DELTA_LIMIT_RST         = 16'h8000;
    localparam logic [EXPO_W-1:0]  SKEW_LIMIT_RST          = 24'd1000;
    localparam logic [EXPO_W-1:0]  EXPOSURE_SKEW_LIMIT_RST = 24'd1000;

    typedef struct packed {
        logic                      side;
        logic [TIME_W-1:0]         now_time;
        logic [TIME_W-1:0]         arrival_time;
        logic [TIME_W-1:0]         capture_end_time;
        logic                      stamp_ok;
        logic [EXPO_W-1:0]         exposure_time;
        logic                      quality_present;
        logic [QUAL_W-1:0]         frame_quality;
        logic signed [DELTA_W-1:0] delta_x;
        logic signed [DELTA_W-1:0] delta_y;
        logic                      source_ok;
        logic [CYCLE_W-1:0]        frame_cycle;
    } obs_t;

    typedef struct packed {
        logic              pair_ok;
        reason_t           pair_reason;
        reason_t           left_code;
        reason_t           right_code;
        logic [TIME_W-1:0] end_time_gap;
        logic [EXPO_W-1:0] exposure_gap;
    } verdict_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     value;
    } cfg_write_t;

    // magnitude of a two's complement delta, one bit wider so -32768 fits
    function automatic logic [DELTA_W:0] delta_mag(input logic signed [DELTA_W-1:0] d);
        logic [DELTA_W:0] ext;
        ext = {1'b0, d};
        if (d[DELTA_W-1])
            return (DELTA_W+1)'(1 << DELTA_W) - ext;
        return ext;
    endfunction

endpackage

// ===== rtl/core/ofpv_if.sv =====
interface ofpv_obs_if;
    logic          valid;
    logic          ready;
    ofpv_pkg::obs_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ofpv_verdict_if;
    logic               valid;
    logic               ready;
    ofpv_pkg::verdict_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ofpv_cfg_if;
    logic                 valid;
    logic                 ready;
    ofpv_pkg::cfg_write_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/optical_flow_pair_validator.sv =====
// Optical-flow pair validator.
// obs: one sensor observation per request, side 0 = left, 1 = right.
// verdict: one pair verdict per right observation; left requests give none.
// cfg: register writes (index, value), always ready; write only when idle.
// Each observation is registered on entry, then judged and paired from the
// entry register, and the verdict is registered. One request per cycle is
// sustained while verdict is not stalled; the rate is set by the entry
// register feeding the verdict register.
// A left observation is kept with its code until the next right one, which
// consumes it; a right one with no left kept reports timeout on the left.
// When verdict is stalled the verdict register holds, a right request in
// the entry register waits, and obs ready drops; left requests still pass
// through while the verdict waits.
// Reset clears the kept left, empties both registers and loads the
// register defaults (timeout 100000, quality 0, deltas 32768, skews 1000).
module optical_flow_pair_validator (
    input  logic                 clk,
    input  logic                 rst_n,
    ofpv_obs_if.sink             obs,
    ofpv_verdict_if.source       verdict,
    ofpv_cfg_if.sink             cfg
);
    import ofpv_pkg::*;

    logic [EXPO_W-1:0]  timeout_limit_reg;
    logic [QUAL_W-1:0]  quality_floor_reg;
    logic [DELTA_W-1:0] delta_x_limit_reg;
    logic [DELTA_W-1:0] delta_y_limit_reg;
    logic [EXPO_W-1:0]  skew_limit_reg;
    logic [EXPO_W-1:0]  exposure_skew_limit_reg;

    logic               in_valid_reg;
    obs_t               in_item_reg;

    logic               held_present_reg;
    reason_t            held_reason_reg;
    logic [TIME_W-1:0]  held_end_time_reg;
    logic [EXPO_W-1:0]  held_exposure_reg;
    logic [CYCLE_W-1:0] held_cycle_reg;

    logic               out_valid_reg;
    verdict_t           out_item_reg;

    logic               out_free;
    logic               advance;
    logic               take_obs;
    logic               is_left;

    logic               age_bad;
    logic [TIME_W-1:0]  age;
    reason_t            code;
    reason_t            left_code;
    reason_t            pair_reason;
    logic [TIME_W-1:0]  end_gap;
    logic [EXPO_W-1:0]  expo_gap;
    verdict_t           verdict_next;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_limit_reg       <= TIMEOUT_LIMIT_RST;
            quality_floor_reg       <= QUALITY_FLOOR_RST;
            delta_x_limit_reg       <= DELTA_LIMIT_RST;
            delta_y_limit_reg       <= DELTA_LIMIT_RST;
            skew_limit_reg          <= SKEW_LIMIT_RST;
            exposure_skew_limit_reg <= EXPOSURE_SKEW_LIMIT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.data.index)
                REG_TIMEOUT_LIMIT:       timeout_limit_reg       <= cfg.data.value;
                REG_QUALITY_FLOOR:       quality_floor_reg       <= cfg.data.value[QUAL_W-1:0];
                REG_DELTA_X_LIMIT:       delta_x_limit_reg       <= cfg.data.value[DELTA_W-1:0];
                REG_DELTA_Y_LIMIT:       delta_y_limit_reg       <= cfg.data.value[DELTA_W-1:0];
                REG_SKEW_LIMIT:          skew_limit_reg          <= cfg.data.value;
                REG_EXPOSURE_SKEW_LIMIT: exposure_skew_limit_reg <= cfg.data.value;
                default:                 ;
            endcase
        end
    end

    // handshake
    assign is_left   = !in_item_reg.side;
    assign out_free  = !out_valid_reg || verdict.ready;
    assign advance   = in_valid_reg && (is_left || out_free);
    assign obs.ready = !in_valid_reg || advance;
    assign take_obs  = obs.valid && obs.ready;

    // per-observation checks
    always_comb
    begin
        age     = in_item_reg.now_time - in_item_reg.arrival_time;
        age_bad = (in_item_reg.now_time < in_item_reg.arrival_time)
               || (age > {{(TIME_W-EXPO_W){1'b0}}, timeout_limit_reg});
        if (age_bad)
            code = RSN_TIMEOUT;
        else if (!in_item_reg.source_ok)
            code = RSN_SOURCE_BAD;
        else if (!in_item_reg.stamp_ok)
            code = RSN_BAD_STAMP;
        else if (in_item_reg.exposure_time == '0)
            code = RSN_BAD_EXPOSURE;
        else if (in_item_reg.quality_present && in_item_reg.frame_quality < quality_floor_reg)
            code = RSN_LOW_QUALITY;
        else if (delta_mag(in_item_reg.delta_x) > {1'b0, delta_x_limit_reg}
              || delta_mag(in_item_reg.delta_y) > {1'b0, delta_y_limit_reg})
            code = RSN_DELTA_OUTLIER;
        else
            code = RSN_NONE;
    end

    // pair checks
    always_comb
    begin
        if (held_present_reg)
        begin
            left_code = held_reason_reg;
            end_gap   = (held_end_time_reg >= in_item_reg.capture_end_time)
                      ? held_end_time_reg - in_item_reg.capture_end_time
                      : in_item_reg.capture_end_time - held_end_time_reg;
            expo_gap  = (held_exposure_reg >= in_item_reg.exposure_time)
                      ? held_exposure_reg - in_item_reg.exposure_time
                      : in_item_reg.exposure_time - held_exposure_reg;
        end
        else
        begin
            left_code = RSN_TIMEOUT;
            end_gap   = '0;
            expo_gap  = '0;
        end

        if (left_code != RSN_NONE)
            pair_reason = left_code;
        else if (code != RSN_NONE)
            pair_reason = code;
        else if (held_cycle_reg != in_item_reg.frame_cycle)
            pair_reason = RSN_CYCLE_MISMATCH;
        else if (end_gap > {{(TIME_W-EXPO_W){1'b0}}, skew_limit_reg})
            pair_reason = RSN_TIME_SKEW;
        else if (expo_gap > exposure_skew_limit_reg)
            pair_reason = RSN_EXPOSURE_SKEW;
        else
            pair_reason = RSN_NONE;

        verdict_next.pair_ok      = (pair_reason == RSN_NONE);
        verdict_next.pair_reason  = pair_reason;
        verdict_next.left_code    = left_code;
        verdict_next.right_code   = code;
        verdict_next.end_time_gap = end_gap;
        verdict_next.exposure_gap = expo_gap;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            held_present_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (take_obs)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                held_present_reg <= is_left;

            if (advance && !is_left)
                out_valid_reg <= 1'b1;
            else if (verdict.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_obs)
            in_item_reg <= obs.data;
        if (advance && is_left)
        begin
            held_reason_reg   <= code;
            held_end_time_reg <= in_item_reg.capture_end_time;
            held_exposure_reg <= in_item_reg.exposure_time;
            held_cycle_reg    <= in_item_reg.frame_cycle;
        end
        if (advance && !is_left)
            out_item_reg <= verdict_next;
    end

    assign verdict.valid = out_valid_reg;
    assign verdict.data  = out_item_reg;

endmodule

// ===== dv/pair_verdict_checker.sv =====
module pair_verdict_checker (
    input  logic        clk,
    input  logic        rst_n,
    ofpv_obs_if         obs,
    ofpv_verdict_if     verdict,
    ofpv_cfg_if         cfg,
    output int unsigned errors,
    output int unsigned pending,
    output int unsigned checked
);
    import ofpv_pkg::*;

    logic [EXPO_W-1:0]  age_limit;
    logic [QUAL_W-1:0]  quality_min;
    logic [DELTA_W-1:0] dx_limit;
    logic [DELTA_W-1:0] dy_limit;
    logic [EXPO_W-1:0]  end_skew_limit;
    logic [EXPO_W-1:0]  expo_skew_limit;

    logic               left_held;
    reason_t            left_reason;
    logic [TIME_W-1:0]  left_end;
    logic [EXPO_W-1:0]  left_expo;
    logic [CYCLE_W-1:0] left_cycle;

    verdict_t           expected_verdicts[$];

    function automatic logic [DELTA_W:0] magnitude(input logic [DELTA_W-1:0] d);
        if (d[DELTA_W-1])
            return 17'h10000 - 17'(d);
        return 17'(d);
    endfunction

    function automatic reason_t judge_observation(input obs_t o);
        if (o.now_time < o.arrival_time
            || (o.now_time - o.arrival_time) > TIME_W'(age_limit))
            return RSN_TIMEOUT;
        if (!o.source_ok)
            return RSN_SOURCE_BAD;
        if (!o.stamp_ok)
            return RSN_BAD_STAMP;
        if (o.exposure_time == '0)
            return RSN_BAD_EXPOSURE;
        if (o.quality_present && o.frame_quality < quality_min)
            return RSN_LOW_QUALITY;
        if (magnitude(o.delta_x) > 17'(dx_limit) || magnitude(o.delta_y) > 17'(dy_limit))
            return RSN_DELTA_OUTLIER;
        return RSN_NONE;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        obs_t              o;
        reason_t           code;
        reason_t           lcode;
        reason_t           pcode;
        logic [TIME_W-1:0] egap;
        logic [EXPO_W-1:0] xgap;
        verdict_t          want;
        verdict_t          got;
        if (!rst_n)
        begin
            age_limit       <= TIMEOUT_LIMIT_RST;
            quality_min     <= QUALITY_FLOOR_RST;
            dx_limit        <= DELTA_LIMIT_RST;
            dy_limit        <= DELTA_LIMIT_RST;
            end_skew_limit  <= SKEW_LIMIT_RST;
            expo_skew_limit <= EXPOSURE_SKEW_LIMIT_RST;
            left_held       <= 1'b0;
            left_reason     <= RSN_NONE;
            left_end        <= '0;
            left_expo       <= '0;
            left_cycle      <= '0;
            expected_verdicts.delete();
            errors  = 0;
            checked = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.data.index)
                    REG_TIMEOUT_LIMIT:       age_limit       <= cfg.data.value;
                    REG_QUALITY_FLOOR:       quality_min     <= cfg.data.value[QUAL_W-1:0];
                    REG_DELTA_X_LIMIT:       dx_limit        <= cfg.data.value[DELTA_W-1:0];
                    REG_DELTA_Y_LIMIT:       dy_limit        <= cfg.data.value[DELTA_W-1:0];
                    REG_SKEW_LIMIT:          end_skew_limit  <= cfg.data.value;
                    REG_EXPOSURE_SKEW_LIMIT: expo_skew_limit <= cfg.data.value;
                    default: ;
                endcase
            end

            if (verdict.valid && verdict.ready)
            begin
                got = verdict.data;
                if (expected_verdicts.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: verdict with no request waiting: reason=%0d",
                                 $realtime, got.pair_reason);
                    errors++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    checked++;
                    if (got.pair_ok !== want.pair_ok || got.pair_reason !== want.pair_reason
                        || got.left_code !== want.left_code
                        || got.right_code !== want.right_code
                        || got.end_time_gap !== want.end_time_gap
                        || got.exposure_gap !== want.exposure_gap)
                    begin
                        if (errors < 10)
                            $display("%0t: verdict mismatch: expected ok=%0b reason=%0d",
                                     $realtime, want.pair_ok, want.pair_reason,
                                     " left=%0d right=%0d end_gap=%0d expo_gap=%0d;",
                                     want.left_code, want.right_code, want.end_time_gap,
                                     want.exposure_gap,
                                     " got ok=%0b reason=%0d left=%0d right=%0d",
                                     got.pair_ok, got.pair_reason,
                                     got.left_code, got.right_code,
                                     " end_gap=%0d expo_gap=%0d",
                                     got.end_time_gap, got.exposure_gap);
                        errors++;
                    end
                end
            end

            if (obs.valid && obs.ready)
            begin
                o = obs.data;
                code = judge_observation(o);
                if (!o.side)
                begin
                    left_held   <= 1'b1;
                    left_reason <= code;
                    left_end    <= o.capture_end_time;
                    left_expo   <= o.exposure_time;
                    left_cycle  <= o.frame_cycle;
                end
                else
                begin
                    if (left_held)
                    begin
                        lcode = left_reason;
                        egap = (left_end >= o.capture_end_time) ? left_end - o.capture_end_time
                                                                : o.capture_end_time - left_end;
                        xgap = (left_expo >= o.exposure_time) ? left_expo - o.exposure_time
                                                              : o.exposure_time - left_expo;
                    end
                    else
                    begin
                        lcode = RSN_TIMEOUT;
                        egap = '0;
                        xgap = '0;
                    end
                    if (lcode != RSN_NONE)
                        pcode = lcode;
                    else if (code != RSN_NONE)
                        pcode = code;
                    else if (left_cycle != o.frame_cycle)
                        pcode = RSN_CYCLE_MISMATCH;
                    else if (egap > TIME_W'(end_skew_limit))
                        pcode = RSN_TIME_SKEW;
                    else if (xgap > expo_skew_limit)
                        pcode = RSN_EXPOSURE_SKEW;
                    else
                        pcode = RSN_NONE;
                    left_held <= 1'b0;
                    want.pair_ok      = (pcode == RSN_NONE);
                    want.pair_reason  = pcode;
                    want.left_code    = lcode;
                    want.right_code   = code;
                    want.end_time_gap = egap;
                    want.exposure_gap = xgap;
                    expected_verdicts.push_back(want);
                end
            end
        end
        pending = expected_verdicts.size();
    end

endmodule

// ===== dv/testbench.sv =====
module testbench;
    import ofpv_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ofpv_obs_if     obs_ch();
    ofpv_verdict_if verdict_ch();
    ofpv_cfg_if     cfg_ch();

    int unsigned verdict_errors;
    int unsigned outstanding;
    int unsigned verdicts_seen;

    int unsigned items_sent = 0;
    int unsigned settings = 0;
    int unsigned quiet_cycles = 0;
    bit          idle_on = 1'b1;

    logic [EXPO_W-1:0]  cur_tmo;
    logic [QUAL_W-1:0]  cur_floor;
    logic [DELTA_W-1:0] cur_dx;
    logic [DELTA_W-1:0] cur_dy;
    logic [EXPO_W-1:0]  cur_skew;
    logic [EXPO_W-1:0]  cur_xskew;

    optical_flow_pair_validator DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .obs     (obs_ch),
        .verdict (verdict_ch),
        .cfg     (cfg_ch)
    );

    pair_verdict_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .obs     (obs_ch),
        .verdict (verdict_ch),
        .cfg     (cfg_ch),
        .errors  (verdict_errors),
        .pending (outstanding),
        .checked (verdicts_seen)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        verdict_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            verdict_ch.ready <= idle_on ? ($urandom_range(99) >= 36) : 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (obs_ch.valid && obs_ch.ready) || (cfg_ch.valid && cfg_ch.ready)
            || (verdict_ch.valid && verdict_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
            $display("[optical_flow_pair_validator] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [TIME_W-1:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic obs_t good_obs(input logic side, input logic [CYCLE_W-1:0] cyc);
        obs_t o;
        o.side             = side;
        o.now_time         = 48'd5000;
        o.arrival_time     = 48'd4500;
        o.capture_end_time = 48'd4000;
        o.stamp_ok         = 1'b1;
        o.exposure_time    = 24'd500;
        o.quality_present  = 1'b1;
        o.frame_quality    = 8'd150;
        o.delta_x          = '0;
        o.delta_y          = '0;
        o.source_ok        = 1'b1;
        o.frame_cycle      = cyc;
        return o;
    endfunction

    function automatic logic [DELTA_W-1:0] rand_delta(input logic [DELTA_W-1:0] lim);
        int unsigned m;
        int r;
        r = $urandom_range(99);
        if (r < 4)
            return 16'h8000;
        if (r < 88)
        begin
            m = (lim > 16'd32767) ? 32767 : lim;
            m = $urandom_range(0, m);
            return $urandom_range(1) ? 16'(m) : 16'(-m);
        end
        return 16'($urandom);
    endfunction

    function automatic logic [TIME_W-1:0] nudge(input logic [TIME_W-1:0] base,
                                               input logic [EXPO_W-1:0] lim);
        logic [TIME_W-1:0] off;
        int r;
        r = $urandom_range(99);
        if (r < 80)
            off = 48'($urandom_range(0, lim));
        else if (r < 92)
            off = 48'(lim) + 48'($urandom_range(1, 2));
        else
            off = rand48();
        return $urandom_range(1) ? base + off : base - off;
    endfunction

    function automatic obs_t make_obs(input logic side, input logic [CYCLE_W-1:0] cyc,
                                      input logic [TIME_W-1:0] t_end,
                                      input logic [EXPO_W-1:0] expo);
        obs_t o;
        logic [TIME_W-1:0] age;
        int r;
        o.side = side;
        o.now_time = rand48();
        r = $urandom_range(99);
        if (r < 85)
            age = 48'($urandom_range(0, cur_tmo));
        else if (r < 92)
            age = 48'(cur_tmo) + 48'($urandom_range(1, 4));
        else
            age = rand48();
        // a large age wraps below zero: clock behind arrival
        o.arrival_time     = o.now_time - age;
        o.capture_end_time = t_end;
        o.source_ok        = ($urandom_range(99) >= 4);
        o.stamp_ok         = ($urandom_range(99) >= 4);
        o.exposure_time    = ($urandom_range(99) < 3) ? '0 : expo;
        o.quality_present  = 1'($urandom_range(1));
        o.frame_quality    = ($urandom_range(99) < 88) ? 8'($urandom_range(cur_floor, 255))
                                                       : 8'($urandom);
        o.delta_x          = rand_delta(cur_dx);
        o.delta_y          = rand_delta(cur_dy);
        o.frame_cycle      = ($urandom_range(99) < 95) ? cyc : $urandom;
        return o;
    endfunction

    task automatic push_obs(input obs_t o);
        while (idle_on && $urandom_range(99) < 36)
        begin
            obs_ch.valid <= 1'b0;
            @(posedge clk);
        end
        obs_ch.valid <= 1'b1;
        obs_ch.data  <= o;
        do
            @(posedge clk);
        while (!obs_ch.ready);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{index: idx, value: val};
        do
            @(posedge clk);
        while (!cfg_ch.ready);
    endtask

    task automatic apply_limits(input logic [CFG_W-1:0] tmo, input logic [CFG_W-1:0] floor,
                                input logic [CFG_W-1:0] dx, input logic [CFG_W-1:0] dy,
                                input logic [CFG_W-1:0] skew, input logic [CFG_W-1:0] xskew);
        write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, 24'($urandom));
        write_reg(REG_TIMEOUT_LIMIT, tmo);
        write_reg(REG_QUALITY_FLOOR, floor);
        write_reg(REG_DELTA_X_LIMIT, dx);
        write_reg(REG_DELTA_Y_LIMIT, dy);
        write_reg(REG_SKEW_LIMIT, skew);
        write_reg(REG_EXPOSURE_SKEW_LIMIT, xskew);
        cfg_ch.valid <= 1'b0;
        cur_tmo   = tmo;
        cur_floor = floor[QUAL_W-1:0];
        cur_dx    = dx[DELTA_W-1:0];
        cur_dy    = dy[DELTA_W-1:0];
        cur_skew  = skew;
        cur_xskew = xskew;
        settings++;
    endtask

    // wait out every verdict, then the pipeline, in case a left request is in flight
    task automatic settle();
        obs_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned stop;
        int kind;
        logic [CYCLE_W-1:0] cyc;
        logic [TIME_W-1:0]  t_end;
        logic [EXPO_W-1:0]  expo;
        stop = items_sent + count;
        while (items_sent < stop)
        begin
            kind  = $urandom_range(99);
            cyc   = $urandom;
            t_end = rand48();
            expo  = ($urandom_range(1)) ? 24'($urandom_range(1, 5000)) : 24'($urandom);
            if (kind >= 90 && kind < 96)
                push_obs(make_obs(1'b1, cyc, t_end, expo));
            else
            begin
                if (kind >= 80 && kind < 90)
                    push_obs(make_obs(1'b0, $urandom, rand48(), 24'($urandom)));
                push_obs(make_obs(1'b0, cyc, t_end, expo));
                if (kind < 90)
                    push_obs(make_obs(1'b1, cyc, nudge(t_end, cur_skew),
                                      24'(nudge(48'(expo), cur_xskew))));
            end
        end
    endtask

    initial
    begin
        obs_t o;
        obs_ch.valid <= 1'b0;
        obs_ch.data  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        rst_n        <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apply_limits(24'd1000, 24'd100, 24'd100, 24'd200, 24'd1000, 24'd1000);

        push_obs(good_obs(1'b1, 32'd1));            // nothing held
        push_obs(good_obs(1'b0, 32'd2));
        push_obs(good_obs(1'b1, 32'd2));
        push_obs(good_obs(1'b1, 32'd2));            // pair already consumed
        o = good_obs(1'b0, 32'd3);
        o.source_ok = 1'b0;
        push_obs(o);
        push_obs(good_obs(1'b0, 32'd3));            // replaces the held left
        push_obs(good_obs(1'b1, 32'd3));
        push_obs(good_obs(1'b0, 32'd4));
        push_obs(good_obs(1'b1, 32'd5));
        o = good_obs(1'b0, 32'd6);                  // age and both gaps at their limits
        o.arrival_time     = o.now_time - 48'd1000;
        o.capture_end_time = 48'd5000;
        o.exposure_time    = 24'd1500;
        push_obs(o);
        push_obs(good_obs(1'b1, 32'd6));
        o = good_obs(1'b0, 32'd7);
        o.capture_end_time = 48'd5001;
        push_obs(o);
        push_obs(good_obs(1'b1, 32'd7));
        o = good_obs(1'b0, 32'd8);
        o.exposure_time = 24'd1501;
        push_obs(o);
        push_obs(good_obs(1'b1, 32'd8));
        o = good_obs(1'b0, 32'd9);                  // clock behind arrival
        o.arrival_time = o.now_time + 48'd1;
        push_obs(o);
        o = good_obs(1'b1, 32'd9);
        o.arrival_time = o.now_time - 48'd1001;
        push_obs(o);
        o = good_obs(1'b0, 32'd10);
        o.source_ok = 1'b0;
        o.stamp_ok  = 1'b0;
        push_obs(o);
        o = good_obs(1'b1, 32'd10);
        o.stamp_ok = 1'b0;
        push_obs(o);
        o = good_obs(1'b0, 32'd11);
        o.exposure_time = '0;
        push_obs(o);
        o = good_obs(1'b1, 32'd11);
        o.frame_quality = 8'd99;
        push_obs(o);
        o = good_obs(1'b0, 32'd12);
        o.quality_present = 1'b0;
        o.frame_quality   = 8'd0;
        o.delta_x         = -16'sd100;
        o.delta_y         = 16'sd200;
        push_obs(o);
        o = good_obs(1'b1, 32'd12);
        o.delta_x = 16'sd101;
        push_obs(o);
        o = good_obs(1'b0, 32'hFFFF_FFFF);
        o.delta_y = -16'sd201;
        push_obs(o);
        o = good_obs(1'b1, 32'hFFFF_FFFF);
        o.now_time         = '1;
        o.arrival_time     = '1;
        o.capture_end_time = '1;
        o.exposure_time    = '1;
        o.frame_quality    = 8'hFF;
        o.delta_x          = 16'sh7FFF;
        o.delta_y          = 16'sh8000;
        push_obs(o);
        settle();

        apply_limits(24'hFFFFFF, 24'hFF, 24'd0, 24'd0, 24'd0, 24'd0);
        run_random(115);
        settle();

        idle_on = 1'b0;
        apply_limits(24'd0, 24'd0, 24'hFFFF, 24'h8000, 24'hFFFFFF, 24'hFFFFFF);
        run_random(115);
        settle();
        idle_on = 1'b1;

        repeat (4)
        begin
            apply_limits(24'($urandom_range(0, 200000)), 24'($urandom),
                         24'($urandom_range(0, 40000)), 24'($urandom),
                         24'($urandom_range(0, 5000)), 24'($urandom_range(0, 5000)));
            run_random(115);
            settle();
        end

        @(negedge clk);
        $display("sent %0d observations over %0d limit settings, including spare-index writes",
                 items_sent, settings);
        $display("checked %0d pair verdicts, %0d mismatches", verdicts_seen, verdict_errors);
        if (verdict_errors == 0)
            $display("[optical_flow_pair_validator] OK");
        else
            $display("[optical_flow_pair_validator] ERROR");
        $finish;
    end

endmodule

// ===== optical_flow_pair_validator.f =====
rtl/core/ofpv_pkg.sv
rtl/core/ofpv_if.sv
rtl/core/optical_flow_pair_validator.sv
dv/pair_verdict_checker.sv
dv/testbench.sv
